// File: sv/vfcm_pkg.sv
// Shared types, constants and lookup functions for the voxel face culling mesher.
package vfcm_pkg;

    localparam int unsigned COORD_BITS_DEFAULT = 15;
    localparam int unsigned KIND_BITS          = 4;
    localparam int unsigned NUM_FACES          = 6;
    localparam int unsigned COUNT_BITS         = 32;
    localparam int unsigned QUEUE_DEPTH        = 2;

    typedef logic [KIND_BITS-1:0]  kind_t;
    typedef logic [NUM_FACES-1:0]  face_mask_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [2:0] {
        FACE_UP    = 3'd0,
        FACE_DOWN  = 3'd1,
        FACE_LEFT  = 3'd2,
        FACE_RIGHT = 3'd3,
        FACE_FRONT = 3'd4,
        FACE_BACK  = 3'd5
    } face_t;

    localparam kind_t KIND_AIR    = 4'd0;
    localparam kind_t KIND_LEAVES = 4'd8;
    localparam kind_t KIND_WATER  = 4'd9;
    localparam kind_t KIND_GRASS  = 4'd10;

    // Offset bits {x, y, z} of one corner of one face.
    function automatic logic [2:0] corner_offset(input face_t face, input logic [1:0] crn);
        logic [11:0] row;
        begin
            case (face)
                FACE_UP:    row = {3'b110, 3'b010, 3'b011, 3'b111};
                FACE_DOWN:  row = {3'b000, 3'b100, 3'b101, 3'b001};
                FACE_LEFT:  row = {3'b011, 3'b010, 3'b000, 3'b001};
                FACE_RIGHT: row = {3'b110, 3'b111, 3'b101, 3'b100};
                FACE_FRONT: row = {3'b111, 3'b011, 3'b001, 3'b101};
                FACE_BACK:  row = {3'b010, 3'b110, 3'b100, 3'b000};
                default:    row = 12'd0;
            endcase
            case (crn)
                2'd0:    corner_offset = row[11:9];
                2'd1:    corner_offset = row[8:6];
                2'd2:    corner_offset = row[5:3];
                default: corner_offset = row[2:0];
            endcase
        end
    endfunction

    // Texture layer by kind and face.
    function automatic logic [3:0] layer_of(input kind_t kind, input face_t face);
        logic top_face;
        logic bottom_face;
        begin
            top_face    = (face == FACE_UP);
            bottom_face = (face == FACE_DOWN);
            case (kind)
                4'd1:    layer_of = 4'd1;
                4'd2:    layer_of = top_face ? 4'd3 : (bottom_face ? 4'd4 : 4'd2);
                4'd3:    layer_of = 4'd4;
                4'd4:    layer_of = 4'd5;
                4'd5:    layer_of = 4'd6;
                4'd6:    layer_of = 4'd7;
                4'd7:    layer_of = (top_face || bottom_face) ? 4'd9 : 4'd8;
                4'd8:    layer_of = 4'd10;
                4'd9:    layer_of = 4'd11;
                4'd10:   layer_of = 4'd12;
                default: layer_of = 4'd0;
            endcase
        end
    endfunction

    // Lowest pending face of a mask.
    function automatic face_t lowest_face(input face_mask_t mask);
        begin
            if (mask[0])      lowest_face = FACE_UP;
            else if (mask[1]) lowest_face = FACE_DOWN;
            else if (mask[2]) lowest_face = FACE_LEFT;
            else if (mask[3]) lowest_face = FACE_RIGHT;
            else if (mask[4]) lowest_face = FACE_FRONT;
            else              lowest_face = FACE_BACK;
        end
    endfunction

endpackage

// File: sv/vfcm_front.sv
// Front end: classify each voxel and queue those of an emitting kind that show at least one face.
module vfcm_front #(
    parameter int unsigned COORD_BITS = vfcm_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  vfcm_pkg::kind_t                         block_kind,
    input  logic signed [COORD_BITS-1:0]            block_x,
    input  logic signed [COORD_BITS-1:0]            block_y,
    input  logic signed [COORD_BITS-1:0]            block_z,
    input  vfcm_pkg::kind_t                         neighbor_above,
    input  vfcm_pkg::kind_t                         neighbor_below,
    input  vfcm_pkg::kind_t                         neighbor_left,
    input  vfcm_pkg::kind_t                         neighbor_right,
    input  vfcm_pkg::kind_t                         neighbor_front,
    input  vfcm_pkg::kind_t                         neighbor_back,
    input  logic                                    q_full,
    output logic                                    q_push,
    output logic [vfcm_pkg::KIND_BITS+vfcm_pkg::NUM_FACES+3*COORD_BITS-1:0] q_push_data
);
    import vfcm_pkg::*;

    face_mask_t face_mask;
    logic       kind_emits;

    function automatic logic see_through(input kind_t nb, input kind_t kind);
        begin
            see_through = ((nb == KIND_AIR) || (nb == KIND_LEAVES) ||
                           (nb == KIND_WATER) || (nb == KIND_GRASS)) && (nb != kind);
        end
    endfunction

    // Mark visible faces in the order up, down, left, right, front, back.
    always_comb
    begin
        face_mask[0] = see_through(neighbor_above, block_kind);
        face_mask[1] = see_through(neighbor_below, block_kind);
        face_mask[2] = see_through(neighbor_left,  block_kind);
        face_mask[3] = see_through(neighbor_right, block_kind);
        face_mask[4] = see_through(neighbor_front, block_kind);
        face_mask[5] = see_through(neighbor_back,  block_kind);
        kind_emits   = (block_kind != KIND_AIR) && (block_kind < KIND_GRASS);
    end

    // Drop voxels with nothing to show; queue the rest.
    assign in_stall    = q_full;
    assign q_push      = in_valid && !q_full && kind_emits && (face_mask != '0);
    assign q_push_data = {block_kind, face_mask, block_x, block_y, block_z};

endmodule

// File: sv/vfcm_queue.sv
// Short FIFO between the classifier and the vertex generator.
module vfcm_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = vfcm_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data
);
    localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] fill_reg;

    assign full      = (fill_reg == CNT_BITS'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head_data = mem[rd_ptr_reg];

    // Store the incoming entry.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// File: sv/vfcm_back.sv
// Back end: walk the visible faces of one voxel and emit four vertices per face.
module vfcm_back #(
    parameter int unsigned COORD_BITS = vfcm_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    q_not_empty,
    input  logic [vfcm_pkg::KIND_BITS+vfcm_pkg::NUM_FACES+3*COORD_BITS-1:0] q_head_data,
    output logic                                    q_pop,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [COORD_BITS:0]              vertex_x,
    output logic signed [COORD_BITS:0]              vertex_y,
    output logic signed [COORD_BITS:0]              vertex_z,
    output logic [2:0]                              face_dir,
    output logic [1:0]                              corner,
    output logic [3:0]                              texture_layer,
    output logic                                    mesh_select,
    output vfcm_pkg::count_t                        vertex_index,
    output logic                                    last
);
    import vfcm_pkg::*;

    // Current voxel
    logic                  busy_reg, busy_next;
    face_mask_t            rem_reg, rem_next;
    logic [1:0]            corner_reg, corner_next;
    kind_t                 kind_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg, z_reg;

    // Mesh counters
    count_t                solid_count_reg, solid_count_next;
    count_t                water_count_reg, water_count_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS:0]   vx_reg, vy_reg, vz_reg;
    face_t                 face_out_reg;
    logic [1:0]            corner_out_reg;
    logic [3:0]            layer_out_reg;
    logic                  mesh_out_reg;
    count_t                index_out_reg;
    logic                  last_out_reg;

    // Unpacked queue head
    kind_t                 head_kind;
    face_mask_t            head_mask;
    logic [COORD_BITS-1:0] head_x, head_y, head_z;

    face_t                 cur_face;
    face_mask_t            rem_after;
    logic [2:0]            offs;
    logic                  water;
    logic                  out_load;
    logic                  emit;
    logic                  finishing;

    assign {head_kind, head_mask, head_x, head_y, head_z} = q_head_data;

    // Pick the face and corner to emit now.
    always_comb
    begin
        cur_face  = lowest_face(rem_reg);
        rem_after = rem_reg & ~(face_mask_t'(1) << cur_face);
        offs      = corner_offset(cur_face, corner_reg);
        water     = (kind_reg == KIND_WATER);
        out_load  = !out_valid_reg || !out_stall;
        emit      = busy_reg && out_load;
        finishing = emit && (corner_reg == 2'd3) && (rem_after == '0);
        q_pop     = q_not_empty && (!busy_reg || finishing);
    end

    // Advance through corners and faces; take the next voxel as this one ends.
    always_comb
    begin
        busy_next        = busy_reg;
        rem_next         = rem_reg;
        corner_next      = corner_reg;
        solid_count_next = solid_count_reg;
        water_count_next = water_count_reg;
        out_valid_next   = out_valid_reg;
        if (q_pop)
        begin
            busy_next   = 1'b1;
            rem_next    = head_mask;
            corner_next = 2'd0;
        end
        else if (finishing)
        begin
            busy_next = 1'b0;
        end
        else if (emit)
        begin
            corner_next = corner_reg + 2'd1;
            if (corner_reg == 2'd3)
            begin
                rem_next = rem_after;
            end
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (water)
            begin
                water_count_next = water_count_reg + 1'b1;
            end
            else
            begin
                solid_count_next = solid_count_reg + 1'b1;
            end
        end
        else if (out_load)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            rem_reg         <= '0;
            corner_reg      <= 2'd0;
            solid_count_reg <= '0;
            water_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            busy_reg        <= busy_next;
            rem_reg         <= rem_next;
            corner_reg      <= corner_next;
            solid_count_reg <= solid_count_next;
            water_count_reg <= water_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Voxel payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg <= head_kind;
            x_reg    <= head_x;
            y_reg    <= head_y;
            z_reg    <= head_z;
        end
    end

    // Vertex payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            vx_reg         <= {x_reg[COORD_BITS-1], x_reg} + {{COORD_BITS{1'b0}}, offs[2]};
            vy_reg         <= {y_reg[COORD_BITS-1], y_reg} + {{COORD_BITS{1'b0}}, offs[1]};
            vz_reg         <= {z_reg[COORD_BITS-1], z_reg} + {{COORD_BITS{1'b0}}, offs[0]};
            face_out_reg   <= cur_face;
            corner_out_reg <= corner_reg;
            layer_out_reg  <= layer_of(kind_reg, cur_face);
            mesh_out_reg   <= water;
            index_out_reg  <= water ? water_count_reg : solid_count_reg;
            last_out_reg   <= finishing;
        end
    end

    assign out_valid     = out_valid_reg;
    assign vertex_x      = vx_reg;
    assign vertex_y      = vy_reg;
    assign vertex_z      = vz_reg;
    assign face_dir      = face_out_reg;
    assign corner        = corner_out_reg;
    assign texture_layer = layer_out_reg;
    assign mesh_select   = mesh_out_reg;
    assign vertex_index  = index_out_reg;
    assign last          = last_out_reg;

endmodule

// File: sv/voxel_face_cull_mesher.sv
// Top level of the voxel face culling mesher: classifier, queue and vertex generator.
//
// One voxel item enters per cycle while the two-entry queue has room. Voxels that
// show no face (air, grass, kinds above ten, or all neighbors opaque or alike) are
// dropped at the input. Each queued voxel then gives four vertex items per visible
// face, one per cycle while out_stall is low; the vertex generator sets the sustained
// rate. The last vertex of a voxel carries last high, and the next voxel is popped
// from the queue as that last vertex is registered. Solid and water vertices are
// numbered by separate 32-bit counters that clear at reset and wrap.
module voxel_face_cull_mesher #(
    parameter int unsigned COORD_BITS = vfcm_pkg::COORD_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  vfcm_pkg::kind_t              block_kind,
    input  logic signed [COORD_BITS-1:0] block_x,
    input  logic signed [COORD_BITS-1:0] block_y,
    input  logic signed [COORD_BITS-1:0] block_z,
    input  vfcm_pkg::kind_t              neighbor_above,
    input  vfcm_pkg::kind_t              neighbor_below,
    input  vfcm_pkg::kind_t              neighbor_left,
    input  vfcm_pkg::kind_t              neighbor_right,
    input  vfcm_pkg::kind_t              neighbor_front,
    input  vfcm_pkg::kind_t              neighbor_back,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS:0]   vertex_x,
    output logic signed [COORD_BITS:0]   vertex_y,
    output logic signed [COORD_BITS:0]   vertex_z,
    output logic [2:0]                   face_dir,
    output logic [1:0]                   corner,
    output logic [3:0]                   texture_layer,
    output logic                         mesh_select,
    output vfcm_pkg::count_t             vertex_index,
    output logic                         last
);
    import vfcm_pkg::*;

    localparam int unsigned ENTRY_BITS = KIND_BITS + NUM_FACES + 3 * COORD_BITS;

    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_not_empty;
    logic [ENTRY_BITS-1:0] q_push_data;
    logic [ENTRY_BITS-1:0] q_head_data;

    vfcm_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .block_kind     (block_kind),
        .block_x        (block_x),
        .block_y        (block_y),
        .block_z        (block_z),
        .neighbor_above (neighbor_above),
        .neighbor_below (neighbor_below),
        .neighbor_left  (neighbor_left),
        .neighbor_right (neighbor_right),
        .neighbor_front (neighbor_front),
        .neighbor_back  (neighbor_back),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_push_data    (q_push_data)
    );

    vfcm_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_data (q_head_data)
    );

    vfcm_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_head_data   (q_head_data),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .vertex_z      (vertex_z),
        .face_dir      (face_dir),
        .corner        (corner),
        .texture_layer (texture_layer),
        .mesh_select   (mesh_select),
        .vertex_index  (vertex_index),
        .last          (last)
    );

endmodule

// File: sv/vfcm_checker.sv
// Port-level checks on the vertex stream of the mesher, bound to the top level.
module vfcm_checker #(
    parameter int unsigned COORD_BITS = vfcm_pkg::COORD_BITS_DEFAULT
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [2:0]                 face_dir,
    input logic [1:0]                 corner,
    input logic [COORD_BITS:0]        vertex_x,
    input vfcm_pkg::count_t           vertex_index,
    input logic                       last
);
    import vfcm_pkg::*;

    // Hold a stalled item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vertex_x) && $stable(vertex_index))
        else $error("stalled vertex changed or vanished");

    // End a voxel only on the fourth corner of a face.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> corner == 2'd3)
        else $error("last flagged on a corner other than the fourth");

    // Keep a face valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> face_dir <= FACE_BACK)
        else $error("face direction out of range");

    // Advance corners within a face without gaps.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last && corner != 2'd3 |=>
            out_valid && corner == $past(corner) + 2'd1 && face_dir == $past(face_dir))
        else $error("corner sequence broken inside a face");

    // Number vertices of one voxel consecutively.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=>
            out_valid && vertex_index == $past(vertex_index) + 1'b1)
        else $error("vertex index not consecutive within a voxel");

endmodule

bind voxel_face_cull_mesher vfcm_checker #(
    .COORD_BITS (COORD_BITS)
) u_vfcm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .face_dir     (face_dir),
    .corner       (corner),
    .vertex_x     (vertex_x),
    .vertex_index (vertex_index),
    .last         (last)
);
